[design/bafus_pkg.sv]
package bafus_pkg;

	// Field and datapath widths
	localparam int ALT_W     = 24;
	localparam int VARIO_W   = 16;
	localparam int ACC_W     = 16;
	localparam int DT_W      = 16;
	localparam int GAIN_W    = 16;
	localparam int FRAC_W    = 16;
	localparam int ERR_W     = ALT_W + 1;
	localparam int VEL_W     = 32;
	localparam int POS_W     = 40;
	localparam int KDT_W     = GAIN_W + DT_W;
	localparam int PSUM_W    = VEL_W + 2;
	localparam int MA_W      = PSUM_W;
	localparam int MB_W      = KDT_W + 1;
	localparam int PROD_W    = ERR_W + MB_W;
	localparam int SUM_W     = POS_W + 3;
	localparam int CORR_SHIFT = 16;
	localparam int STEP_SHIFT = 17;

	// Configuration registers
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN = 2'd1;
	localparam logic [GAIN_W-1:0] POS_GAIN_RST = 16'd43691;
	localparam logic [GAIN_W-1:0] VEL_GAIN_RST = 16'd12945;

	// Microcode fields
	localparam int STEP_W = 4;
	localparam logic [2:0] A_ZERO  = 3'd0;
	localparam logic [2:0] A_VGAIN = 3'd1;
	localparam logic [2:0] A_PGAIN = 3'd2;
	localparam logic [2:0] A_ACC   = 3'd3;
	localparam logic [2:0] A_ERR   = 3'd4;
	localparam logic [2:0] A_SUM   = 3'd5;

	localparam logic [1:0] B_ZERO = 2'd0;
	localparam logic [1:0] B_DT   = 2'd1;
	localparam logic [1:0] B_KV   = 2'd2;
	localparam logic [1:0] B_KP   = 2'd3;

	localparam logic [2:0] D_NONE = 3'd0;
	localparam logic [2:0] D_KV   = 3'd1;
	localparam logic [2:0] D_KP   = 3'd2;
	localparam logic [2:0] D_VINC = 3'd3;
	localparam logic [2:0] D_PROD = 3'd4;

	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_ARM   = 4'd1;
	localparam logic [3:0] OP_READ  = 4'd2;
	localparam logic [3:0] OP_ERR   = 4'd3;
	localparam logic [3:0] OP_VCOR  = 4'd4;
	localparam logic [3:0] OP_PCOR  = 4'd5;
	localparam logic [3:0] OP_STEP  = 4'd6;
	localparam logic [3:0] OP_OUT   = 4'd7;
	localparam logic [3:0] OP_UNARM = 4'd8;

	localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
	localparam logic [STEP_W-1:0] STEP_OUT   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_UNARM = 4'd9;

	typedef struct packed {
		logic [2:0] a_sel;
		logic [1:0] b_sel;
		logic [2:0] dst;
		logic [3:0] op;
		logic       jmp_unarm;
		logic       wait_out;
		logic       last_step;
	} ucode_t;

	// Control store: one word per step
	function automatic ucode_t uc_rom(input logic [STEP_W-1:0] s);
		ucode_t w;
		w = '{a_sel: A_ZERO, b_sel: B_ZERO, dst: D_NONE, op: OP_NONE,
			jmp_unarm: 1'b0, wait_out: 1'b0, last_step: 1'b0};
		case (s)
			4'd0: begin
				w.a_sel = A_VGAIN; w.b_sel = B_DT; w.dst = D_KV;
				w.op = OP_ARM; w.jmp_unarm = 1'b1;
			end
			4'd1: begin
				w.a_sel = A_PGAIN; w.b_sel = B_DT; w.dst = D_KP; w.op = OP_READ;
			end
			4'd2: begin
				w.a_sel = A_ACC; w.b_sel = B_DT; w.dst = D_VINC; w.op = OP_ERR;
			end
			4'd3: begin
				w.a_sel = A_ERR; w.b_sel = B_KV; w.dst = D_PROD;
			end
			4'd4: begin
				w.a_sel = A_ERR; w.b_sel = B_KP; w.dst = D_PROD; w.op = OP_VCOR;
			end
			4'd5: begin
				w.op = OP_PCOR;
			end
			4'd6: begin
				w.a_sel = A_SUM; w.b_sel = B_DT; w.dst = D_PROD;
			end
			4'd7: begin
				w.op = OP_STEP;
			end
			4'd8: begin
				w.op = OP_OUT; w.wait_out = 1'b1; w.last_step = 1'b1;
			end
			4'd9: begin
				w.op = OP_UNARM; w.wait_out = 1'b1; w.last_step = 1'b1;
			end
			default: begin
				w.last_step = 1'b1;
			end
		endcase
		return w;
	endfunction

	// Saturate a wide sum to the velocity range
	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-VEL_W:0] top;
		top = x[SUM_W-1:VEL_W-1];
		if (top == '0 || top == '1)
			return x[VEL_W-1:0];
		else if (x[SUM_W-1])
			return {1'b1, {(VEL_W-1){1'b0}}};
		else
			return {1'b0, {(VEL_W-1){1'b1}}};
	endfunction

	// Saturate a wide sum to the position range
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-POS_W:0] top;
		top = x[SUM_W-1:POS_W-1];
		if (top == '0 || top == '1)
			return x[POS_W-1:0];
		else if (x[SUM_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

endpackage

[design/baro_accel_altitude_fusion_core.sv]
// Channel   Handshake               Payload
// in        in_valid / in_ready     armed, raw_altitude, ground_altitude, near_ground,
//                                   accel_up, dt_seconds
// out       out_valid / out_ready   updated, est_altitude, est_vario
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// An armed tick runs steps 0..8 of the control store; no new tick is accepted until its last step completes.
// An unarmed tick runs steps 0 and 9.
// The step sequence is set by the single shared multiplier (six products) and
// the saturating adds that use them.
// Reset clears the estimate, ring valid bits, index and active flag, and loads the default gains.
// A result waits in the output register; the last step holds while it is not taken.
module baro_accel_altitude_fusion_core
	import bafus_pkg::*;
#(
	parameter int HIST_DEPTH = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        armed,
	input  logic signed [ALT_W-1:0]     raw_altitude,
	input  logic signed [ALT_W-1:0]     ground_altitude,
	input  logic                        near_ground,
	input  logic signed [ACC_W-1:0]     accel_up,
	input  logic [DT_W-1:0]             dt_seconds,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        updated,
	output logic signed [ALT_W-1:0]     est_altitude,
	output logic signed [VARIO_W-1:0]   est_vario,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [GAIN_W-1:0]           cfg_data
);

	localparam int IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HIST_DEPTH - 1);

	// Sequencer and state
	logic                      busy_q;
	logic [STEP_W-1:0]         step_q;
	logic                      active_q;
	logic [IDX_W-1:0]          idx_q;
	logic [HIST_DEPTH-1:0]     valid_q;
	logic signed [POS_W-1:0]   pos_q;
	logic signed [VEL_W-1:0]   vel_q;
	logic [GAIN_W-1:0]         pgain_q;
	logic [GAIN_W-1:0]         vgain_q;
	logic                      out_valid_q;

	// Latched input item
	logic                      armed_q;
	logic signed [ALT_W-1:0]   raw_q;
	logic signed [ALT_W-1:0]   gnd_q;
	logic                      near_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [DT_W-1:0]           dt_q;

	// Datapath registers
	logic [KDT_W-1:0]          kv_q;
	logic [KDT_W-1:0]          kp_q;
	logic signed [VEL_W-1:0]   vinc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [PSUM_W-1:0]  sum_q;
	logic signed [ALT_W-1:0]   ring_rd_q;
	logic                      hv_q;
	logic signed [ALT_W-1:0]   ring_mem [HIST_DEPTH];

	// Result register
	logic                      upd_q;
	logic signed [ALT_W-1:0]   alt_q;
	logic signed [VARIO_W-1:0] vario_q;

	ucode_t                    uc;
	logic                      stall;
	logic                      go_unarm;
	logic                      fire_last;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [MA_W+MB_W-1:0] mul_p;
	logic signed [ALT_W-1:0]   baro_c;
	logic signed [ALT_W-1:0]   hist_c;
	logic signed [ALT_W-1:0]   alt_c;
	logic signed [VARIO_W-1:0] vario_c;

	assign in_ready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign updated   = upd_q;
	assign est_altitude = alt_q;
	assign est_vario = vario_q;

	// Control word decode
	assign uc        = uc_rom(step_q);
	assign stall     = uc.wait_out && out_valid_q && !out_ready;
	assign go_unarm  = uc.jmp_unarm && !armed_q;
	assign fire_last = busy_q && uc.last_step && !stall;

	// Shared multiplier operand select
	always_comb begin
		case (uc.a_sel)
			A_VGAIN: mul_a = MA_W'(vgain_q);
			A_PGAIN: mul_a = MA_W'(pgain_q);
			A_ACC:   mul_a = MA_W'(acc_q);
			A_ERR:   mul_a = MA_W'(err_q);
			A_SUM:   mul_a = sum_q;
			default: mul_a = '0;
		endcase
		case (uc.b_sel)
			B_DT:    mul_b = MB_W'(dt_q);
			B_KV:    mul_b = MB_W'(kv_q);
			B_KP:    mul_b = MB_W'(kp_q);
			default: mul_b = '0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Baro with air-cushion clamp, delayed estimate from the ring
	assign baro_c = (near_q && raw_q < gnd_q) ? gnd_q : raw_q;
	assign hist_c = hv_q ? ring_rd_q : '0;

	// Whole cm / cm/s, truncated toward zero
	assign alt_c = ALT_W'(pos_q >>> FRAC_W)
		+ {{(ALT_W-1){1'b0}}, (pos_q[POS_W-1] && |pos_q[FRAC_W-1:0])};
	assign vario_c = VARIO_W'(vel_q >>> FRAC_W)
		+ {{(VARIO_W-1){1'b0}}, (vel_q[VEL_W-1] && |vel_q[FRAC_W-1:0])};

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_FIRST;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			step_q <= STEP_FIRST;
		end else if (busy_q) begin
			if (go_unarm)
				step_q <= STEP_UNARM;
			else if (uc.last_step) begin
				if (!stall)
					busy_q <= 1'b0;
			end else
				step_q <= step_q + 1'b1;
		end
	end

	// Gains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgain_q <= POS_GAIN_RST;
			vgain_q <= VEL_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POS_GAIN: pgain_q <= cfg_data;
				CFG_VEL_GAIN: vgain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			valid_q  <= '0;
			pos_q    <= '0;
			vel_q    <= '0;
		end else if (busy_q) begin
			case (uc.op)
				OP_ARM: begin
					if (armed_q && !active_q) begin
						active_q <= 1'b1;
						idx_q    <= '0;
						valid_q  <= '0;
						pos_q    <= '0;
						vel_q    <= '0;
					end
				end
				OP_VCOR: vel_q <= sat_vel(SUM_W'(vel_q) + SUM_W'(prod_q >>> CORR_SHIFT));
				OP_PCOR: pos_q <= sat_pos(SUM_W'(pos_q) + SUM_W'(prod_q >>> CORR_SHIFT));
				OP_STEP: begin
					pos_q <= sat_pos(SUM_W'(pos_q) + SUM_W'(prod_q >>> STEP_SHIFT));
					vel_q <= sat_vel(SUM_W'(vel_q) + SUM_W'(vinc_q));
				end
				OP_OUT: begin
					if (!stall) begin
						valid_q[idx_q] <= 1'b1;
						idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
					end
				end
				OP_UNARM: begin
					if (!stall)
						active_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Input latch and datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			armed_q <= armed;
			raw_q   <= raw_altitude;
			gnd_q   <= ground_altitude;
			near_q  <= near_ground;
			acc_q   <= accel_up;
			dt_q    <= dt_seconds;
		end
		if (busy_q) begin
			case (uc.dst)
				D_KV:    kv_q   <= mul_p[KDT_W-1:0];
				D_KP:    kp_q   <= mul_p[KDT_W-1:0];
				D_VINC:  vinc_q <= mul_p[VEL_W-1:0];
				D_PROD:  prod_q <= mul_p[PROD_W-1:0];
				default: ;
			endcase
			case (uc.op)
				OP_READ: hv_q  <= valid_q[idx_q];
				OP_ERR:  err_q <= ERR_W'(baro_c) - ERR_W'(hist_c);
				OP_PCOR: sum_q <= (PSUM_W'(vel_q) <<< 1) + PSUM_W'(vinc_q);
				default: ;
			endcase
		end
		if (fire_last) begin
			if (uc.op == OP_OUT) begin
				upd_q   <= 1'b1;
				alt_q   <= alt_c;
				vario_q <= vario_c;
			end else begin
				upd_q   <= 1'b0;
				alt_q   <= '0;
				vario_q <= '0;
			end
		end
	end

	// History ring
	always_ff @(posedge clk) begin
		if (busy_q && uc.op == OP_OUT && !stall)
			ring_mem[idx_q] <= alt_c;
		if (busy_q && uc.op == OP_READ)
			ring_rd_q <= ring_mem[idx_q];
	end

	// Result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire_last)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// A result only appears after the sequencer ran its last step
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q)
			&& ($past(step_q) == STEP_OUT || $past(step_q) == STEP_UNARM))
		else $error("result raised outside a final step");

	// Unarmed results carry zero fields
	a_unarmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !upd_q |-> alt_q == '0 && vario_q == '0)
		else $error("unarmed result with nonzero fields");

	// Ring index stays inside the ring
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("history index out of range");

	// Step counter never leaves the program
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_UNARM)
		else $error("step counter out of program");

	// An updated result implies the filter was active when it was produced
	a_upd_active: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && upd_q |-> active_q)
		else $error("update without active filter");

endmodule

[tb/sv/altitude_fusion_check.sv]
module altitude_fusion_check
	import bafus_pkg::*;
#(
	parameter int HIST_DEPTH = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      armed,
	input  logic signed [ALT_W-1:0]   raw_altitude,
	input  logic signed [ALT_W-1:0]   ground_altitude,
	input  logic                      near_ground,
	input  logic signed [ACC_W-1:0]   accel_up,
	input  logic [DT_W-1:0]           dt_seconds,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      updated,
	input  logic signed [ALT_W-1:0]   est_altitude,
	input  logic signed [VARIO_W-1:0] est_vario,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data,
	output int                        errors,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Saturation bounds of the Q formats and of the output fields
	localparam longint POS_HI   = (longint'(1) <<< (POS_W - 1)) - 1;
	localparam longint POS_LO   = -(longint'(1) <<< (POS_W - 1));
	localparam longint VEL_HI   = (longint'(1) <<< (VEL_W - 1)) - 1;
	localparam longint VEL_LO   = -(longint'(1) <<< (VEL_W - 1));
	localparam longint ALT_HI   = (longint'(1) <<< (ALT_W - 1)) - 1;
	localparam longint ALT_LO   = -(longint'(1) <<< (ALT_W - 1));
	localparam longint VARIO_HI = (longint'(1) <<< (VARIO_W - 1)) - 1;
	localparam longint VARIO_LO = -(longint'(1) <<< (VARIO_W - 1));

	typedef struct packed {
		logic                      updated;
		logic signed [ALT_W-1:0]   altitude;
		logic signed [VARIO_W-1:0] vario;
	} fix_t;

	// Shadow of the filter state
	logic [GAIN_W-1:0]       pos_gain;
	logic [GAIN_W-1:0]       vel_gain;
	longint                  est_pos;
	longint                  est_vel;
	logic signed [ALT_W-1:0] alt_ring [HIST_DEPTH];
	int                      ring_ptr;
	logic                    fusing;

	fix_t expected_fixes [$];
	fix_t seen;
	fix_t want;

	function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// Q.16 to whole units, rounding toward zero
	function automatic longint whole_units(input longint x);
		return (x < 0) ? -((-x) >>> FRAC_W) : (x >>> FRAC_W);
	endfunction

	// One tick of the delayed-correction filter; updates the shadow state
	function automatic fix_t advance_fusion(
		input logic                    arm,
		input logic signed [ALT_W-1:0] raw,
		input logic signed [ALT_W-1:0] gnd,
		input logic                    near,
		input logic signed [ACC_W-1:0] acc,
		input logic [DT_W-1:0]         dt
	);
		fix_t   f;
		longint baro;
		longint err;
		longint kv;
		longint kp;
		longint dt_l;
		longint vinc;
		longint alt;
		longint vario;
		f = '0;
		if (!arm) begin
			fusing = 1'b0;
			return f;
		end
		// first armed tick restarts the filter
		if (!fusing) begin
			fusing  = 1'b1;
			est_pos = 0;
			est_vel = 0;
			foreach (alt_ring[i]) alt_ring[i] = '0;
			ring_ptr = 0;
		end
		// air cushion: baro below ground is ignored near ground
		baro = (near && raw < gnd) ? longint'(gnd) : longint'(raw);
		err  = baro - longint'(alt_ring[ring_ptr]);
		dt_l = longint'(dt);
		kv   = longint'(vel_gain);
		kv   = kv * dt_l;
		kp   = longint'(pos_gain);
		kp   = kp * dt_l;
		est_vel = clamp_to(est_vel + ((err * kv) >>> CORR_SHIFT), VEL_LO, VEL_HI);
		est_pos = clamp_to(est_pos + ((err * kp) >>> CORR_SHIFT), POS_LO, POS_HI);
		vinc = longint'(acc);
		vinc = vinc * dt_l;
		est_pos = clamp_to(est_pos + (((2 * est_vel + vinc) * dt_l) >>> STEP_SHIFT),
			POS_LO, POS_HI);
		est_vel = clamp_to(est_vel + vinc, VEL_LO, VEL_HI);
		alt   = clamp_to(whole_units(est_pos), ALT_LO, ALT_HI);
		vario = clamp_to(whole_units(est_vel), VARIO_LO, VARIO_HI);
		alt_ring[ring_ptr] = alt[ALT_W-1:0];
		ring_ptr = (ring_ptr + 1) % HIST_DEPTH;
		f.updated  = 1'b1;
		f.altitude = alt[ALT_W-1:0];
		f.vario    = vario[VARIO_W-1:0];
		return f;
	endfunction

	// Watch all three channels; results are checked before the new tick is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_gain = POS_GAIN_RST;
			vel_gain = VEL_GAIN_RST;
			est_pos  = 0;
			est_vel  = 0;
			foreach (alt_ring[i]) alt_ring[i] = '0;
			ring_ptr = 0;
			fusing   = 1'b0;
			expected_fixes.delete();
			errors   = 0;
			pending  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_POS_GAIN)
					pos_gain = cfg_data;
				else if (cfg_index == CFG_VEL_GAIN)
					vel_gain = cfg_data;
			end
			if (out_valid && out_ready) begin
				seen = '{updated: updated, altitude: est_altitude, vario: est_vario};
				if (expected_fixes.size() == 0) begin
					$display("%0t ns: unexpected result transfer: updated=%0b altitude=%0d vario=%0d",
						$time, seen.updated, seen.altitude, seen.vario);
					errors++;
				end else begin
					want = expected_fixes.pop_front();
					if (seen.updated !== want.updated) begin
						$display("%0t ns: updated expected %0b got %0b",
							$time, want.updated, seen.updated);
						errors++;
					end
					if (seen.altitude !== want.altitude) begin
						$display("%0t ns: est_altitude expected %0d got %0d",
							$time, want.altitude, seen.altitude);
						errors++;
					end
					if (seen.vario !== want.vario) begin
						$display("%0t ns: est_vario expected %0d got %0d",
							$time, want.vario, seen.vario);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_fixes.push_back(advance_fusion(armed, raw_altitude, ground_altitude,
					near_ground, accel_up, dt_seconds));
			pending = expected_fixes.size();
		end
	end

endmodule

[tb/sv/tb.sv]
module tb;
	import bafus_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST         = 10;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_TICKS  = 150;
	localparam int HOLD_AFTER   = 400;   // input transfers before the long output hold
	localparam int HOLD_CYCLES  = 300;
	localparam int TRAIL_CYCLES = 30;
	localparam logic [DT_W-1:0] NOMINAL_DT = 16'd1311;  // 20 ms in Q0.16
	localparam int CUSHION_CM   = 200;

	// Indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	localparam logic signed [ALT_W-1:0] ALT_TOP    = {1'b0, {(ALT_W-1){1'b1}}};
	localparam logic signed [ALT_W-1:0] ALT_BOTTOM = {1'b1, {(ALT_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_TOP    = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_BOTTOM = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [DT_W-1:0]         DT_TOP     = '1;
	localparam logic [GAIN_W-1:0]       GAIN_TOP   = '1;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      armed;
	logic signed [ALT_W-1:0]   raw_altitude;
	logic signed [ALT_W-1:0]   ground_altitude;
	logic                      near_ground;
	logic signed [ACC_W-1:0]   accel_up;
	logic [DT_W-1:0]           dt_seconds;
	logic                      out_valid;
	logic                      out_ready;
	logic                      updated;
	logic signed [ALT_W-1:0]   est_altitude;
	logic signed [VARIO_W-1:0] est_vario;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [GAIN_W-1:0]         cfg_data;

	int errors;
	int pending;
	int in_xfers;
	int cycles;
	int send_steady;
	int recv_steady;
	int flight_left;
	int ground_cm;
	int height_cm;

	baro_accel_altitude_fusion_core #(.HIST_DEPTH(HIST)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.armed(armed), .raw_altitude(raw_altitude), .ground_altitude(ground_altitude),
		.near_ground(near_ground), .accel_up(accel_up), .dt_seconds(dt_seconds),
		.out_valid(out_valid), .out_ready(out_ready),
		.updated(updated), .est_altitude(est_altitude), .est_vario(est_vario),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	altitude_fusion_check #(.HIST_DEPTH(HIST)) check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.armed(armed), .raw_altitude(raw_altitude), .ground_altitude(ground_altitude),
		.near_ground(near_ground), .accel_up(accel_up), .dt_seconds(dt_seconds),
		.out_valid(out_valid), .out_ready(out_ready),
		.updated(updated), .est_altitude(est_altitude), .est_vario(est_vario),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			in_xfers++;

	// Gap length in cycles: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Result side: random stalls, steady stretches, one long hold
	initial begin
		int g;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && in_xfers >= HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				held = 1'b1;
			end else begin
				if (recv_steady == 0 && $urandom_range(99) == 0)
					recv_steady = $urandom_range(30, 120);
				if (recv_steady > 0) begin
					recv_steady--;
					g = 0;
				end else begin
					g = pick_gap();
				end
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// One tick transfer, then a random idle gap
	task automatic send_tick(
		input logic                    arm,
		input logic signed [ALT_W-1:0] raw,
		input logic signed [ALT_W-1:0] gnd,
		input logic                    near,
		input logic signed [ACC_W-1:0] acc,
		input logic [DT_W-1:0]         dt
	);
		int g;
		@(negedge clk);
		in_valid        <= 1'b1;
		armed           <= arm;
		raw_altitude    <= raw;
		ground_altitude <= gnd;
		near_ground     <= near;
		accel_up        <= acc;
		dt_seconds      <= dt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (send_steady == 0 && $urandom_range(99) == 0)
			send_steady = $urandom_range(20, 60);
		if (send_steady > 0) begin
			send_steady--;
			g = 0;
		end else begin
			g = pick_gap();
		end
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// Stop offering ticks and wait until every result has been taken
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] pg, input logic [GAIN_W-1:0] vg);
		write_reg(CFG_POS_GAIN, pg);
		write_reg(CFG_VEL_GAIN, vg);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Field extremes, saturation, air cushion, dt corners, disarm and rearm
	task automatic directed_ticks();
		int k;
		send_tick(1'b0, ALT_TOP, ALT_BOTTOM, 1'b1, ACC_BOTTOM, DT_TOP);
		send_tick(1'b1, 24'sd1000, '0, 1'b0, '0, NOMINAL_DT);
		repeat (3) send_tick(1'b1, ALT_TOP, ALT_BOTTOM, 1'b0, ACC_TOP, DT_TOP);
		send_tick(1'b1, ALT_BOTTOM, ALT_TOP, 1'b1, '0, NOMINAL_DT);
		send_tick(1'b1, ALT_BOTTOM, ALT_TOP, 1'b0, ACC_BOTTOM, DT_TOP);
		repeat (3) send_tick(1'b1, ALT_BOTTOM, ALT_BOTTOM, 1'b1, ACC_BOTTOM, DT_TOP);
		send_tick(1'b1, -24'sd50, 24'sd100, 1'b1, -16'sd981, NOMINAL_DT);
		send_tick(1'b1, 24'sd300, '0, 1'b1, '0, 16'd0);
		send_tick(1'b1, -24'sd1, '0, 1'b0, 16'sd1, 16'd1);
		send_tick(1'b0, '0, '0, 1'b0, '0, NOMINAL_DT);
		// rearm, then run long enough for the history ring to wrap
		for (k = 0; k < 12; k++)
			send_tick(1'b1, ALT_W'(100 * k), '0, 1'b0, 16'sd50, NOMINAL_DT);
	endtask

	// Random flights: armed runs with plausible baro and accel, plus noise ticks
	task automatic fly(input int count);
		int n;
		int noise;
		logic arm;
		logic near;
		logic signed [ALT_W-1:0] raw;
		logic signed [ALT_W-1:0] gnd;
		logic signed [ACC_W-1:0] acc;
		logic [DT_W-1:0] dt;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < 15) begin
				arm  = 1'($urandom);
				raw  = ALT_W'($urandom);
				gnd  = ALT_W'($urandom);
				near = 1'($urandom);
				acc  = ACC_W'($urandom);
				dt   = DT_W'($urandom);
			end else if (flight_left == 0) begin
				arm  = 1'b0;
				raw  = ALT_W'($urandom);
				gnd  = ALT_W'(ground_cm);
				near = 1'($urandom);
				acc  = ACC_W'($urandom);
				dt   = NOMINAL_DT;
				if ($urandom_range(2) == 0) begin
					flight_left = $urandom_range(5, 90);
					ground_cm   = int'($urandom_range(400000)) - 200000;
					height_cm   = 0;
				end
			end else begin
				flight_left--;
				height_cm += int'($urandom_range(80)) - 40;
				if (height_cm < -300)
					height_cm = -300;
				noise = int'($urandom_range(120)) - 60;
				// occasional baro glitch
				if ($urandom_range(49) == 0)
					noise += int'($urandom_range(200000)) - 100000;
				arm  = 1'b1;
				gnd  = ALT_W'(ground_cm);
				raw  = ALT_W'(ground_cm + height_cm + noise);
				near = (height_cm < CUSHION_CM) ? 1'b1 : ($urandom_range(19) == 0);
				acc  = ACC_W'(int'($urandom_range(1600)) - 800);
				if ($urandom_range(9) == 0)
					dt = DT_W'($urandom);
				else
					dt = DT_W'(int'(NOMINAL_DT) + int'($urandom_range(200)) - 100);
			end
			send_tick(arm, raw, gnd, near, acc, dt);
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		armed           = 1'b0;
		raw_altitude    = '0;
		ground_altitude = '0;
		near_ground     = 1'b0;
		accel_up        = '0;
		dt_seconds      = '0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_POS_GAIN;
		cfg_data        = '0;
		cycles          = 0;
		in_xfers        = 0;
		send_steady     = 0;
		recv_steady     = 0;
		flight_left     = 0;
		ground_cm       = 0;
		height_cm       = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset gains first
		directed_ticks();

		wait_idle();
		set_gains('0, '0);
		fly(PHASE_TICKS);

		wait_idle();
		set_gains(GAIN_TOP, GAIN_TOP);
		fly(PHASE_TICKS);

		// random gains, with writes to unused indexes in between
		wait_idle();
		write_reg(CFG_SPARE_A, GAIN_W'($urandom));
		write_reg(CFG_POS_GAIN, GAIN_W'($urandom));
		write_reg(CFG_SPARE_B, GAIN_W'($urandom));
		write_reg(CFG_VEL_GAIN, GAIN_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		fly(PHASE_TICKS);

		wait_idle();
		set_gains(GAIN_TOP, '0);
		fly(PHASE_TICKS);

		wait_idle();
		set_gains(POS_GAIN_RST, VEL_GAIN_RST);
		fly(PHASE_TICKS);

		wait_idle();
		repeat (TRAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
